// File: sv/wrst_pkg.sv
// ----------------------------------------------------------------------------
// wrst_pkg
// shared types and constants for the windowed regression slope trend block
// ----------------------------------------------------------------------------
`default_nettype none

package wrst_pkg;

   localparam int SAMPLE_W  = 15;
   localparam int SLOPE_W   = 16;
   localparam int TREND_W   = 2;
   localparam int HELD_W    = 4;

   // sums sized for the largest window of 64 samples
   localparam int SY_W      = 21;
   localparam int SXY_W     = 26;
   localparam int SX_W      = 11;
   localparam int SXX_W     = 17;
   localparam int PROD_W    = 34;
   localparam int NUM_W     = 35;
   localparam int DEN_W     = 23;
   localparam int LIM_W     = 38;
   localparam int MAG_W     = 34;
   localparam int CMP_W     = 40;
   localparam int CNT_W     = 6;
   localparam int DIV_STEPS = MAG_W;

   localparam logic [SAMPLE_W-1:0] THRESH_RESET = 15'd128;

   localparam logic [TREND_W-1:0] TREND_STABLE  = 2'd0;
   localparam logic [TREND_W-1:0] TREND_RISING  = 2'd1;
   localparam logic [TREND_W-1:0] TREND_FALLING = 2'd2;

   typedef struct packed {
      logic push;
      logic full;
      logic mul;
      logic sub;
      logic start;
      logic step;
      logic short_fit;
   } lane_ctrl_type;

endpackage

`default_nettype wire

// File: sv/wrst_lane.sv
// ----------------------------------------------------------------------------
// wrst_lane
// one metric: sample window, running sums, numerator and serial divider
// ----------------------------------------------------------------------------
`default_nettype none

module wrst_lane #(
   parameter int WINDOW = 10,
   parameter int NW     = 4
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire wrst_pkg::lane_ctrl_type         ctrl,
   input  wire  [wrst_pkg::SAMPLE_W-1:0]        sample,
   input  wire  [NW-1:0]                        xpos,
   input  wire  [NW-1:0]                        fill,
   input  wire  [wrst_pkg::SX_W-1:0]            sx,
   input  wire  [wrst_pkg::DEN_W-1:0]           den,
   input  wire  [wrst_pkg::LIM_W-1:0]           lim,
   output logic [wrst_pkg::SLOPE_W-1:0]         slope,
   output logic [wrst_pkg::TREND_W-1:0]         trend
);

   logic [wrst_pkg::SAMPLE_W-1:0] win_ff [WINDOW];
   logic [wrst_pkg::SY_W-1:0]     sy_ff, sy_in, rest;
   logic [wrst_pkg::SXY_W-1:0]    sxy_ff, sxy_in;
   logic [wrst_pkg::PROD_W-1:0]   p1_ff, p2_ff;
   logic signed [wrst_pkg::NUM_W-1:0] num_ff;
   logic [wrst_pkg::MAG_W-1:0]    quo_ff, quo_in;
   logic [wrst_pkg::DEN_W:0]      rem_ff, rem_in, trial_rem;
   logic [wrst_pkg::DEN_W+1:0]    trial;
   logic                          neg_ff;
   logic signed [wrst_pkg::CMP_W-1:0] num_x, lim_x;
   logic [wrst_pkg::MAG_W-1:0]    num_mag;

   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         win_ff[0] <= sample;
         for (int k = 1; k < WINDOW; k++) begin
            win_ff[k] <= win_ff[k-1];
         end
      end
   end

   always_comb begin
      rest   = sy_ff - (ctrl.full ? wrst_pkg::SY_W'(win_ff[WINDOW-1]) : '0);
      sy_in  = (ctrl.full ? rest : sy_ff) + wrst_pkg::SY_W'(sample);
      sxy_in = sxy_ff - (ctrl.full ? wrst_pkg::SXY_W'(rest) : '0)
             + wrst_pkg::SXY_W'(wrst_pkg::SXY_W'(xpos) * wrst_pkg::SXY_W'(sample));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sy_ff  <= '0;
         sxy_ff <= '0;
      end else if (ctrl.push) begin
         sy_ff  <= sy_in;
         sxy_ff <= sxy_in;
      end
   end

   // products, then numerator
   always_ff @(posedge clock) begin
      if (ctrl.mul) begin
         p1_ff <= wrst_pkg::PROD_W'(fill) * wrst_pkg::PROD_W'(sxy_ff);
         p2_ff <= wrst_pkg::PROD_W'(sx) * wrst_pkg::PROD_W'(sy_ff);
      end
      if (ctrl.sub) begin
         num_ff <= signed'(wrst_pkg::NUM_W'(p1_ff)) - signed'(wrst_pkg::NUM_W'(p2_ff));
      end
   end

   // restoring divider, one quotient bit a cycle
   always_comb begin
      num_mag   = num_ff[wrst_pkg::NUM_W-1] ? wrst_pkg::MAG_W'(-num_ff)
                                            : wrst_pkg::MAG_W'(num_ff);
      trial_rem = {rem_ff[wrst_pkg::DEN_W-1:0], quo_ff[wrst_pkg::MAG_W-1]};
      trial     = {1'b0, trial_rem} - {2'b00, den};
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      if (ctrl.start) begin
         rem_in = '0;
         quo_in = num_mag;
      end else if (ctrl.step) begin
         if (!trial[wrst_pkg::DEN_W+1]) begin
            rem_in = trial[wrst_pkg::DEN_W:0];
            quo_in = {quo_ff[wrst_pkg::MAG_W-2:0], 1'b1};
         end else begin
            rem_in = trial_rem;
            quo_in = {quo_ff[wrst_pkg::MAG_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (ctrl.start) begin
         neg_ff <= num_ff[wrst_pkg::NUM_W-1];
      end
   end

   // saturate, sign and trend compare
   always_comb begin
      num_x = wrst_pkg::CMP_W'(num_ff);
      lim_x = signed'(wrst_pkg::CMP_W'(lim));
      slope = '0;
      trend = wrst_pkg::TREND_STABLE;
      if (!ctrl.short_fit) begin
         if (neg_ff) begin
            slope = (quo_ff > wrst_pkg::MAG_W'(32768)) ? 16'h8000
                  : wrst_pkg::SLOPE_W'(-quo_ff);
         end else begin
            slope = (quo_ff > wrst_pkg::MAG_W'(32767)) ? 16'h7fff
                  : wrst_pkg::SLOPE_W'(quo_ff);
         end
         if (num_x > lim_x) begin
            trend = wrst_pkg::TREND_RISING;
         end else if (num_x < -lim_x) begin
            trend = wrst_pkg::TREND_FALLING;
         end
      end
   end

endmodule

`default_nettype wire

// File: sv/windowed_regression_slope_trend.sv
// ----------------------------------------------------------------------------
// windowed_regression_slope_trend
// least-squares slope and trend over a sliding window of three metrics
// ----------------------------------------------------------------------------
// Each accepted word carries one sample per metric; three lanes keep their
// windows and running sums side by side and one result word follows per
// request. An item passes from acceptance through the MUL, SUB and LIM states
// and then DIV_STEPS divider steps, one quotient bit per cycle in each lane,
// before DONE loads the result register; the next request is taken once the
// result sits in the output register, so items are processed one at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_regression_slope_trend #(
   parameter int WINDOW = 10
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [14:0] req_cpu_sample,
   input  wire  [14:0] req_ram_sample,
   input  wire  [14:0] req_gpu_sample,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [15:0] rsp_cpu_slope,
   output logic [15:0] rsp_ram_slope,
   output logic [15:0] rsp_gpu_slope,
   output logic [1:0]  rsp_cpu_trend,
   output logic [1:0]  rsp_ram_trend,
   output logic [1:0]  rsp_gpu_trend,
   output logic [3:0]  rsp_samples_held,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [14:0] csr_trend_threshold
);

   localparam int NW = $clog2(WINDOW + 1);
   localparam int NL = 3;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_SUB  = 3'd2;
   localparam logic [2:0] ST_LIM  = 3'd3;
   localparam logic [2:0] ST_DIV  = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   logic [2:0]                     state_ff, state_in;
   logic [wrst_pkg::CNT_W-1:0]     cnt_ff, cnt_in;
   logic [NW-1:0]                  fill_ff, fill_in, xpos;
   logic [wrst_pkg::SX_W-1:0]      sx_ff;
   logic [wrst_pkg::SXX_W-1:0]     sxx_ff;
   logic [wrst_pkg::DEN_W-1:0]     d1_ff, d2_ff, den_ff;
   logic [wrst_pkg::LIM_W-1:0]     lim_ff;
   logic [wrst_pkg::SAMPLE_W-1:0]  thr_ff;
   logic                           full, accept, load;
   wrst_pkg::lane_ctrl_type        ctrl;
   logic [wrst_pkg::SAMPLE_W-1:0]  samples [NL];
   logic [wrst_pkg::SLOPE_W-1:0]   slopes  [NL];
   logic [wrst_pkg::TREND_W-1:0]   trends  [NL];
   logic                           rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE) && !reset;
   assign accept    = req_valid && req_ready;
   assign csr_ready = !reset;
   assign full      = (fill_ff == NW'(WINDOW));
   assign xpos      = full ? NW'(WINDOW - 1) : fill_ff;
   assign fill_in   = full ? fill_ff : fill_ff + NW'(1);
   assign load      = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   assign samples[0] = req_cpu_sample;
   assign samples[1] = req_ram_sample;
   assign samples[2] = req_gpu_sample;

   always_comb begin
      ctrl.push      = accept;
      ctrl.full      = full;
      ctrl.mul       = (state_ff == ST_MUL);
      ctrl.sub       = (state_ff == ST_SUB);
      ctrl.start     = (state_ff == ST_LIM);
      ctrl.step      = (state_ff == ST_DIV);
      ctrl.short_fit = (fill_ff < NW'(2));
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: state_in = ST_SUB;
         ST_SUB: state_in = ST_LIM;
         ST_LIM: begin
            state_in = ST_DIV;
            cnt_in   = '0;
         end
         ST_DIV: begin
            cnt_in = cnt_ff + wrst_pkg::CNT_W'(1);
            if (cnt_ff == wrst_pkg::CNT_W'(wrst_pkg::DIV_STEPS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         fill_ff  <= '0;
         sx_ff    <= '0;
         sxx_ff   <= '0;
         thr_ff   <= wrst_pkg::THRESH_RESET;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (csr_valid) begin
            thr_ff <= csr_trend_threshold;
         end
         if (accept) begin
            fill_ff <= fill_in;
            if (!full) begin
               sx_ff  <= sx_ff + wrst_pkg::SX_W'(fill_ff);
               sxx_ff <= sxx_ff + wrst_pkg::SXX_W'(wrst_pkg::SXX_W'(fill_ff)
                                                  * wrst_pkg::SXX_W'(fill_ff));
            end
         end
      end
   end

   // shared denominator and threshold limit
   always_ff @(posedge clock) begin
      if (ctrl.mul) begin
         d1_ff <= wrst_pkg::DEN_W'(wrst_pkg::DEN_W'(fill_ff) * wrst_pkg::DEN_W'(sxx_ff));
         d2_ff <= wrst_pkg::DEN_W'(wrst_pkg::DEN_W'(sx_ff) * wrst_pkg::DEN_W'(sx_ff));
      end
      if (ctrl.sub) begin
         den_ff <= d1_ff - d2_ff;
      end
      if (ctrl.start) begin
         lim_ff <= wrst_pkg::LIM_W'(thr_ff) * wrst_pkg::LIM_W'(den_ff);
      end
   end

   for (genvar g = 0; g < NL; g++) begin : g_lane
      wrst_lane #(
         .WINDOW (WINDOW),
         .NW     (NW)
      ) u_lane (
         .clock  (clock),
         .reset  (reset),
         .ctrl   (ctrl),
         .sample (samples[g]),
         .xpos   (xpos),
         .fill   (fill_ff),
         .sx     (sx_ff),
         .den    (den_ff),
         .lim    (lim_ff),
         .slope  (slopes[g]),
         .trend  (trends[g])
      );
   end

   // result word register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_cpu_slope    <= slopes[0];
         rsp_ram_slope    <= slopes[1];
         rsp_gpu_slope    <= slopes[2];
         rsp_cpu_trend    <= trends[0];
         rsp_ram_trend    <= trends[1];
         rsp_gpu_trend    <= trends[2];
         rsp_samples_held <= wrst_pkg::HELD_W'(fill_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// File: sim/windowed_regression_slope_trend_test.sv
// ----------------------------------------------------------------------------
// windowed_regression_slope_trend_test
// self-checking bench for the sliding-window slope and trend block
// ----------------------------------------------------------------------------
// Sends sample words through the request channel with random idle bursts on
// both sides, predicts each slope and trend from an in-bench copy of the three
// sample windows and the threshold, and compares every result word against
// the oldest prediction. The threshold is changed between phases while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_regression_slope_trend_test;

   localparam int WIN = 10;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic [wrst_pkg::SLOPE_W-1:0] cpu_slope;
      logic [wrst_pkg::SLOPE_W-1:0] ram_slope;
      logic [wrst_pkg::SLOPE_W-1:0] gpu_slope;
      logic [wrst_pkg::TREND_W-1:0] cpu_trend;
      logic [wrst_pkg::TREND_W-1:0] ram_trend;
      logic [wrst_pkg::TREND_W-1:0] gpu_trend;
      logic [wrst_pkg::HELD_W-1:0]  held;
   } fit_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [14:0] req_cpu_sample = '0;
   logic [14:0] req_ram_sample = '0;
   logic [14:0] req_gpu_sample = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [15:0] rsp_cpu_slope, rsp_ram_slope, rsp_gpu_slope;
   logic [1:0] rsp_cpu_trend, rsp_ram_trend, rsp_gpu_trend;
   logic [3:0] rsp_samples_held;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [14:0] csr_trend_threshold = '0;

   windowed_regression_slope_trend #(.WINDOW(WIN)) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_cpu_sample(req_cpu_sample), .req_ram_sample(req_ram_sample),
      .req_gpu_sample(req_gpu_sample),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_cpu_slope(rsp_cpu_slope), .rsp_ram_slope(rsp_ram_slope),
      .rsp_gpu_slope(rsp_gpu_slope),
      .rsp_cpu_trend(rsp_cpu_trend), .rsp_ram_trend(rsp_ram_trend),
      .rsp_gpu_trend(rsp_gpu_trend), .rsp_samples_held(rsp_samples_held),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_trend_threshold(csr_trend_threshold)
   );

   always #10 clock = ~clock;

   logic [wrst_pkg::SAMPLE_W-1:0] win_hist [3][WIN];
   int unsigned fill_level = 0;
   logic [wrst_pkg::SAMPLE_W-1:0] threshold_now = wrst_pkg::THRESH_RESET;
   fit_word_type pending_fits [$];
   int unsigned mismatch_count = 0;
   int unsigned fits_checked = 0;
   int unsigned idle_cycles = 0;
   bit rsp_stall_on = 1'b1;
   bit send_gaps_on = 1'b1;
   int unsigned thresholds_used = 1;

   function automatic void fit_metric(input int m, input int unsigned n,
                                      output logic [wrst_pkg::SLOPE_W-1:0] slope,
                                      output logic [wrst_pkg::TREND_W-1:0] trend);
      longint sx, sy, sxy, sxx, num, den, q, lim;
      sx = 0; sy = 0; sxy = 0; sxx = 0;
      slope = '0;
      trend = wrst_pkg::TREND_STABLE;
      if (n < 2) return;
      for (int i = 0; i < n; i++) begin
         sx += i;
         sy += win_hist[m][i];
         sxy += longint'(i) * win_hist[m][i];
         sxx += i * i;
      end
      num = n * sxy - sx * sy;
      den = n * sxx - sx * sx;
      q = num / den;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      slope = q[wrst_pkg::SLOPE_W-1:0];
      lim = longint'(threshold_now) * den;
      if (num > lim) trend = wrst_pkg::TREND_RISING;
      else if (num < -lim) trend = wrst_pkg::TREND_FALLING;
   endfunction

   function automatic fit_word_type predict_fit(input logic [14:0] c,
                                                input logic [14:0] r,
                                                input logic [14:0] g);
      fit_word_type f;
      logic [14:0] s [3];
      s[0] = c; s[1] = r; s[2] = g;
      for (int m = 0; m < 3; m++) begin
         if (fill_level < WIN) win_hist[m][fill_level] = s[m];
         else begin
            for (int i = 0; i < WIN - 1; i++) win_hist[m][i] = win_hist[m][i+1];
            win_hist[m][WIN-1] = s[m];
         end
      end
      if (fill_level < WIN) fill_level++;
      fit_metric(0, fill_level, f.cpu_slope, f.cpu_trend);
      fit_metric(1, fill_level, f.ram_slope, f.ram_trend);
      fit_metric(2, fill_level, f.gpu_slope, f.gpu_trend);
      f.held = fill_level[wrst_pkg::HELD_W-1:0];
      return f;
   endfunction

   // result checker and consumer stalls
   always @(posedge clock) begin
      fit_word_type got, want;
      int unsigned stall;
      if (!reset) begin
         if (req_valid && req_ready || rsp_valid && rsp_ready || csr_valid && csr_ready)
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (rsp_valid && rsp_ready) begin
            got = {rsp_cpu_slope, rsp_ram_slope, rsp_gpu_slope, rsp_cpu_trend,
                   rsp_ram_trend, rsp_gpu_trend, rsp_samples_held};
            fits_checked++;
            if (pending_fits.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) $display("unexpected result word %h", got);
            end else begin
               want = pending_fits[0];
               pending_fits.delete(0);
               if (got !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch: expected %h got %h (slopes %0d %0d %0d)",
                              want, got, $signed(got.cpu_slope),
                              $signed(got.ram_slope), $signed(got.gpu_slope));
               end
            end
         end
         if (rsp_stall_on && $urandom_range(0, 7) == 0) begin
            stall = $urandom_range(1, 13);
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
            rsp_ready <= 1'b1;
         end else
            rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (idle_cycles > WATCHDOG_LIMIT) begin
         $display("windowed_regression_slope_trend_test: errors");
         $finish;
      end
   end

   task automatic send_samples(input logic [14:0] c, input logic [14:0] r,
                               input logic [14:0] g);
      if (send_gaps_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cpu_sample <= c;
      req_ram_sample <= r;
      req_gpu_sample <= g;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_fits.insert(pending_fits.size(), predict_fit(c, r, g));
   endtask

   task automatic drain_results;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_fits.size() != 0) @(posedge clock);
      repeat (45) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [14:0] v);
      drain_results();
      csr_valid <= 1'b1;
      csr_trend_threshold <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      threshold_now = v;
      thresholds_used++;
   endtask

   function automatic logic [14:0] any_sample();
      case ($urandom_range(0, 9))
         0: return 15'h7fff;
         1: return 15'd0;
         2: return 15'($urandom_range(25601, 32767));
         default: return 15'($urandom_range(0, 25600));
      endcase
   endfunction

   task automatic test_extremes;
      send_samples(15'd25600, 15'd0, 15'h7fff);
      send_samples(15'd0, 15'd25600, 15'd0);
      for (int i = 0; i < 10; i++)
         send_samples(15'(i * 2560), 15'(25600 - i * 2560), i[0] ? 15'h7fff : 15'd0);
      for (int i = 0; i < 6; i++)
         send_samples(15'd12800, 15'h2aaa, 15'h5555);
   endtask

   task automatic test_threshold_edges;
      write_threshold(15'd0);
      for (int i = 0; i < 5; i++) send_samples(15'd100, 15'(100 + i), 15'(100 - i));
      write_threshold(15'd1);
      for (int i = 0; i < 4; i++) send_samples(15'(i * 2), 15'(i), 15'd0);
      write_threshold(15'h7fff);
      for (int i = 0; i < 4; i++) send_samples(15'h7fff * i[0], 15'd0, 15'd0);
   endtask

   task automatic test_random_ramps(input int unsigned count);
      logic [14:0] base [3];
      int step [3];
      for (int k = 0; k < count; k++) begin
         if (k % 12 == 0)
            for (int m = 0; m < 3; m++) begin
               base[m] = 15'($urandom_range(0, 25600));
               step[m] = int'($urandom_range(0, 800)) - 400;
            end
         if ($urandom_range(0, 3) == 0)
            send_samples(any_sample(), any_sample(), any_sample());
         else begin
            for (int m = 0; m < 3; m++)
               base[m] = 15'(int'(base[m]) + step[m] + int'($urandom_range(0, 60)) - 30);
            send_samples(base[0], base[1], base[2]);
         end
      end
   endtask

   task automatic test_random_thresholds;
      for (int p = 0; p < 6; p++) begin
         write_threshold(15'($urandom_range(0, 600)));
         test_random_ramps(200);
      end
      write_threshold(15'd25600);
      test_random_ramps(100);
   endtask

   task automatic test_full_rate;
      drain_results();
      rsp_stall_on = 1'b0;
      send_gaps_on = 1'b0;
      write_threshold(wrst_pkg::THRESH_RESET);
      test_random_ramps(300);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_threshold_edges();
      test_random_ramps(200);
      test_random_thresholds();
      test_full_rate();
      drain_results();
      $display("covered %0d result words over %0d threshold settings",
               fits_checked, thresholds_used);
      $display("including extreme, out-of-range, short-window and idle-drain cases");
      if (mismatch_count == 0 && pending_fits.size() == 0)
         $display("windowed_regression_slope_trend_test: clean");
      else
         $display("windowed_regression_slope_trend_test: errors");
      $finish;
   end

endmodule

`default_nettype wire
